[hw/rtl/xxh_pkg.sv]
`timescale 1ns / 1ps
package xxh_pkg;

	localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
	localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
	localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
	localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
	localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_APPEND,
		OP_MA_STRIPE,
		OP_MA_LANE,
		OP_MA_ROT31,
		OP_MA_LANEADD,
		OP_LANE_WB,
		OP_H_CONV,
		OP_H_SHORT,
		OP_H_LEN,
		OP_MA_HXOR,
		OP_H_P4,
		OP_MA_TAIL8,
		OP_MA_R27,
		OP_MA_TAIL4,
		OP_MA_R23,
		OP_H_P3,
		OP_MA_TAIL1,
		OP_MA_R11,
		OP_H_P,
		OP_MA_AV1,
		OP_MA_AV2,
		OP_H_AV,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] lane;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic long_msg;
		logic stripe_full;
		logic rem_ge8;
		logic rem_ge4;
		logic rem_nz;
	} dp_sts_t;

	function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
		rotl = (v << n) | (v >> (64 - n));
	endfunction

endpackage

[hw/rtl/xxhash64_digest_core.sv]
`timescale 1ns / 1ps
// xxh64 digest core
// a beat is taken only in the idle state, after the previous beat and the work it started are done;
// a beat that completes a 32-byte stripe adds 4 lane rounds of 2 multiplies on one shared 3-step 32x32 unit
// after the last beat, the new hash is held back while the previous hash still waits
// one message beat at a time; the hash waits in an output register
// arst_n clears seed, lanes, fill, length and all control state
module xxhash64_digest_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // data_word [63:0], byte_count [67:64], zero pad
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // hash [63:0]
);

	xxh_pkg::dp_cmd_t cmd;
	xxh_pkg::dp_sts_t sts;
	logic             in_beat;

	assign in_beat = s_axis_tvalid & s_axis_tready;

	xxh_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_beat   (in_beat),
		.in_last   (s_axis_tlast),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid)
	);

	xxh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_beat   (in_beat),
		.in_word   (s_axis_tdata[63:0]),
		.in_count  (s_axis_tdata[67:64]),
		.cmd       (cmd),
		.sts       (sts),
		.hash      (m_axis_tdata)
	);

endmodule

[hw/rtl/xxh_mul.sv]
`timescale 1ns / 1ps
module xxh_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p,
	output logic        done
);

	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  step_q;
	logic        busy_q, done_q;
	logic [63:0] pp;

	always_comb begin
		case (step_q)
			2'd0:    pp = a_q[31:0] * b_q[31:0];
			2'd1:    pp = {a_q[31:0] * b_q[63:32], 32'b0};
			default: pp = {a_q[63:32] * b_q[31:0], 32'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= 2'd0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			acc_q <= (step_q == 2'd0) ? pp : acc_q + pp;
		end
	end

	assign p    = acc_q;
	assign done = done_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("multiply started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while still busy");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && step_q == 2'd2 |=> done_q) else $error("multiply did not finish");
`endif

endmodule

[hw/rtl/xxh_dp.sv]
`timescale 1ns / 1ps
module xxh_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [63:0]     cfg_wdata,
	input  logic            in_beat,
	input  logic [63:0]     in_word,
	input  logic [3:0]      in_count,
	input  xxh_pkg::dp_cmd_t cmd,
	output xxh_pkg::dp_sts_t sts,
	output logic [63:0]     hash
);

	logic [63:0]  seed_q, len_q, h_q, out_q, word_q;
	logic [63:0]  acc_q [4];
	logic [255:0] buf_q, stripe_q, buf_nx, stripe_nx;
	logic [4:0]   fill_q, rem_q;
	logic [3:0]   cnt_q;
	logic         open_q, full_q;
	logic [5:0]   sum;
	logic [63:0]  ma, mb, p, hx, conv, av1;
	logic         mstart, mdone;

	assign sum = {1'b0, fill_q} + {2'b0, cnt_q};

	always_comb begin
		logic [4:0] off;
		logic       wr;
		buf_nx    = buf_q;
		stripe_nx = buf_q;
		for (int j = 0; j < 32; j++) begin
			off = 5'(j) - fill_q;
			wr  = {1'b0, off} < {2'b0, cnt_q};
			if (wr) begin
				buf_nx[8*j +: 8] = word_q[8*off[2:0] +: 8];
				if (5'(j) >= fill_q)
					stripe_nx[8*j +: 8] = word_q[8*off[2:0] +: 8];
			end
		end
	end

	assign hx   = h_q ^ p;
	assign conv = xxh_pkg::rotl(acc_q[0], 1) + xxh_pkg::rotl(acc_q[1], 7)
		+ xxh_pkg::rotl(acc_q[2], 12) + xxh_pkg::rotl(acc_q[3], 18);
	assign av1  = h_q ^ (h_q >> 33);

	always_comb begin
		mstart = 1'b1;
		ma     = p;
		mb     = xxh_pkg::PRIME1;
		case (cmd.op)
			xxh_pkg::OP_MA_STRIPE: begin
				ma = stripe_q[64*cmd.lane +: 64];
				mb = xxh_pkg::PRIME2;
			end
			xxh_pkg::OP_MA_LANE: begin
				ma = acc_q[cmd.lane];
				mb = xxh_pkg::PRIME2;
			end
			xxh_pkg::OP_MA_ROT31:   ma = xxh_pkg::rotl(p, 31);
			xxh_pkg::OP_MA_LANEADD: ma = xxh_pkg::rotl(acc_q[cmd.lane] + p, 31);
			xxh_pkg::OP_MA_HXOR:    ma = hx;
			xxh_pkg::OP_MA_TAIL8: begin
				ma = buf_q[63:0];
				mb = xxh_pkg::PRIME2;
			end
			xxh_pkg::OP_MA_R27:     ma = xxh_pkg::rotl(hx, 27);
			xxh_pkg::OP_MA_TAIL4:   ma = {32'b0, buf_q[31:0]};
			xxh_pkg::OP_MA_R23: begin
				ma = xxh_pkg::rotl(hx, 23);
				mb = xxh_pkg::PRIME2;
			end
			xxh_pkg::OP_MA_TAIL1: begin
				ma = {56'b0, buf_q[7:0]};
				mb = xxh_pkg::PRIME5;
			end
			xxh_pkg::OP_MA_R11:     ma = xxh_pkg::rotl(hx, 11);
			xxh_pkg::OP_MA_AV1: begin
				ma = av1;
				mb = xxh_pkg::PRIME2;
			end
			xxh_pkg::OP_MA_AV2: begin
				ma = p ^ (p >> 29);
				mb = xxh_pkg::PRIME3;
			end
			default: mstart = 1'b0;
		endcase
	end

	xxh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.a      (ma),
		.b      (mb),
		.p      (p),
		.done   (mdone)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			open_q <= 1'b0;
			fill_q <= '0;
			len_q  <= '0;
			rem_q  <= '0;
			full_q <= 1'b0;
			for (int k = 0; k < 4; k++)
				acc_q[k] <= '0;
		end else begin
			if (cfg_we)
				seed_q <= cfg_wdata;
			if (in_beat && !open_q) begin
				acc_q[0] <= seed_q + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
				acc_q[1] <= seed_q + xxh_pkg::PRIME2;
				acc_q[2] <= seed_q;
				acc_q[3] <= seed_q - xxh_pkg::PRIME1;
				fill_q   <= '0;
				len_q    <= '0;
				open_q   <= 1'b1;
			end
			case (cmd.op)
				xxh_pkg::OP_APPEND: begin
					fill_q <= sum[4:0];
					full_q <= sum[5];
					len_q  <= len_q + {60'b0, cnt_q};
				end
				xxh_pkg::OP_LANE_WB: acc_q[cmd.lane] <= p;
				xxh_pkg::OP_H_CONV, xxh_pkg::OP_H_SHORT: begin
					rem_q  <= fill_q;
					open_q <= 1'b0;
				end
				xxh_pkg::OP_MA_TAIL8: rem_q <= rem_q - 5'd8;
				xxh_pkg::OP_MA_TAIL4: rem_q <= rem_q - 5'd4;
				xxh_pkg::OP_MA_TAIL1: rem_q <= rem_q - 5'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			word_q <= in_word;
			cnt_q  <= (in_count > 4'd8) ? 4'd8 : in_count;
		end
		case (cmd.op)
			xxh_pkg::OP_APPEND: begin
				buf_q    <= buf_nx;
				stripe_q <= stripe_nx;
			end
			xxh_pkg::OP_H_CONV:  h_q <= conv;
			xxh_pkg::OP_H_SHORT: h_q <= acc_q[2] + xxh_pkg::PRIME5;
			xxh_pkg::OP_H_LEN:   h_q <= h_q + len_q;
			xxh_pkg::OP_H_P4:    h_q <= p + xxh_pkg::PRIME4;
			xxh_pkg::OP_H_P3:    h_q <= p + xxh_pkg::PRIME3;
			xxh_pkg::OP_H_P:     h_q <= p;
			xxh_pkg::OP_H_AV:    h_q <= p ^ (p >> 32);
			xxh_pkg::OP_MA_TAIL8: buf_q <= buf_q >> 64;
			xxh_pkg::OP_MA_TAIL4: buf_q <= buf_q >> 32;
			xxh_pkg::OP_MA_TAIL1: buf_q <= buf_q >> 8;
			xxh_pkg::OP_EMIT:    out_q <= h_q;
			default: ;
		endcase
	end

	assign sts.mul_done    = mdone;
	assign sts.long_msg    = |len_q[63:5];
	assign sts.stripe_full = full_q;
	assign sts.rem_ge8     = rem_q >= 5'd8;
	assign sts.rem_ge4     = rem_q >= 5'd4;
	assign sts.rem_nz      = rem_q != 5'd0;
	assign hash            = out_q;

endmodule

[hw/rtl/xxh_ctl.sv]
`timescale 1ns / 1ps
module xxh_ctl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_beat,
	input  logic             in_last,
	input  logic             out_ready,
	input  xxh_pkg::dp_sts_t sts,
	output xxh_pkg::dp_cmd_t cmd,
	output logic             in_ready,
	output logic             out_valid
);

	typedef enum logic [4:0] {
		S_IDLE, S_APPEND, S_CHECK, S_WAIT,
		S_LS_A, S_LS_B, S_LS_WB,
		S_FIN, S_CONV, S_SHORT,
		S_MG_A, S_MG_B, S_MG_C, S_MG_D,
		S_LEN, S_TD,
		S_T8_A, S_T8_B, S_T8_C, S_T8_D,
		S_T4_A, S_T4_B, S_T4_C,
		S_T1_A, S_T1_B, S_T1_C,
		S_AV_A, S_AV_B, S_AV_C,
		S_OUT, S_EMIT
	} state_t;

	state_t          state_q, ret_q, nxt, nret;
	xxh_pkg::dp_op_t op_q;
	logic [1:0]      lane_q;
	logic            last_q, ready_q, ovalid_q;

	function automatic xxh_pkg::dp_op_t op_of(input state_t s);
		case (s)
			S_APPEND: op_of = xxh_pkg::OP_APPEND;
			S_LS_A:   op_of = xxh_pkg::OP_MA_STRIPE;
			S_LS_B:   op_of = xxh_pkg::OP_MA_LANEADD;
			S_LS_WB:  op_of = xxh_pkg::OP_LANE_WB;
			S_CONV:   op_of = xxh_pkg::OP_H_CONV;
			S_SHORT:  op_of = xxh_pkg::OP_H_SHORT;
			S_MG_A:   op_of = xxh_pkg::OP_MA_LANE;
			S_MG_B:   op_of = xxh_pkg::OP_MA_ROT31;
			S_MG_C:   op_of = xxh_pkg::OP_MA_HXOR;
			S_MG_D:   op_of = xxh_pkg::OP_H_P4;
			S_LEN:    op_of = xxh_pkg::OP_H_LEN;
			S_T8_A:   op_of = xxh_pkg::OP_MA_TAIL8;
			S_T8_B:   op_of = xxh_pkg::OP_MA_ROT31;
			S_T8_C:   op_of = xxh_pkg::OP_MA_R27;
			S_T8_D:   op_of = xxh_pkg::OP_H_P4;
			S_T4_A:   op_of = xxh_pkg::OP_MA_TAIL4;
			S_T4_B:   op_of = xxh_pkg::OP_MA_R23;
			S_T4_C:   op_of = xxh_pkg::OP_H_P3;
			S_T1_A:   op_of = xxh_pkg::OP_MA_TAIL1;
			S_T1_B:   op_of = xxh_pkg::OP_MA_R11;
			S_T1_C:   op_of = xxh_pkg::OP_H_P;
			S_AV_A:   op_of = xxh_pkg::OP_MA_AV1;
			S_AV_B:   op_of = xxh_pkg::OP_MA_AV2;
			S_AV_C:   op_of = xxh_pkg::OP_H_AV;
			S_EMIT:   op_of = xxh_pkg::OP_EMIT;
			default:  op_of = xxh_pkg::OP_NOP;
		endcase
	endfunction

	always_comb begin
		nxt  = state_q;
		nret = ret_q;
		case (state_q)
			S_IDLE:   if (in_beat) nxt = S_APPEND;
			S_APPEND: nxt = S_CHECK;
			S_CHECK: begin
				if (sts.stripe_full) nxt = S_LS_A;
				else if (last_q)     nxt = S_FIN;
				else                 nxt = S_IDLE;
			end
			S_WAIT:   if (sts.mul_done) nxt = ret_q;
			S_LS_A: begin nxt = S_WAIT; nret = S_LS_B;  end
			S_LS_B: begin nxt = S_WAIT; nret = S_LS_WB; end
			S_LS_WB: begin
				if (lane_q != 2'd3) nxt = S_LS_A;
				else if (last_q)    nxt = S_FIN;
				else                nxt = S_IDLE;
			end
			S_FIN:    nxt = sts.long_msg ? S_CONV : S_SHORT;
			S_CONV:   nxt = S_MG_A;
			S_SHORT:  nxt = S_LEN;
			S_MG_A: begin nxt = S_WAIT; nret = S_MG_B; end
			S_MG_B: begin nxt = S_WAIT; nret = S_MG_C; end
			S_MG_C: begin nxt = S_WAIT; nret = S_MG_D; end
			S_MG_D:   nxt = (lane_q == 2'd3) ? S_LEN : S_MG_A;
			S_LEN:    nxt = S_TD;
			S_TD: begin
				if (sts.rem_ge8)      nxt = S_T8_A;
				else if (sts.rem_ge4) nxt = S_T4_A;
				else if (sts.rem_nz)  nxt = S_T1_A;
				else                  nxt = S_AV_A;
			end
			S_T8_A: begin nxt = S_WAIT; nret = S_T8_B; end
			S_T8_B: begin nxt = S_WAIT; nret = S_T8_C; end
			S_T8_C: begin nxt = S_WAIT; nret = S_T8_D; end
			S_T8_D:   nxt = S_TD;
			S_T4_A: begin nxt = S_WAIT; nret = S_T4_B; end
			S_T4_B: begin nxt = S_WAIT; nret = S_T4_C; end
			S_T4_C:   nxt = S_TD;
			S_T1_A: begin nxt = S_WAIT; nret = S_T1_B; end
			S_T1_B: begin nxt = S_WAIT; nret = S_T1_C; end
			S_T1_C:   nxt = S_TD;
			S_AV_A: begin nxt = S_WAIT; nret = S_AV_B; end
			S_AV_B: begin nxt = S_WAIT; nret = S_AV_C; end
			S_AV_C:   nxt = S_OUT;
			S_OUT:    if (!ovalid_q || out_ready) nxt = S_EMIT;
			S_EMIT:   nxt = S_IDLE;
			default:  nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			op_q     <= xxh_pkg::OP_NOP;
			lane_q   <= 2'd0;
			last_q   <= 1'b0;
			ready_q  <= 1'b1;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			ret_q   <= nret;
			op_q    <= op_of(nxt);
			ready_q <= (nxt == S_IDLE);
			if (in_beat)
				last_q <= in_last;
			if (state_q == S_LS_WB || state_q == S_MG_D)
				lane_q <= lane_q + 2'd1;
			// valid rises together with the hash register load
			if (state_q == S_EMIT)
				ovalid_q <= 1'b1;
			else if (ovalid_q && out_ready)
				ovalid_q <= 1'b0;
		end
	end

	assign cmd.op    = op_q;
	assign cmd.lane  = lane_q;
	assign in_ready  = ready_q;
	assign out_valid = ovalid_q;

`ifndef SYNTHESIS
	a_beat_appends: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> state_q == S_APPEND && !ready_q) else $error("beat not appended");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> state_q == S_WAIT) else $error("product outside wait");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> !ovalid_q) else $error("emit over a waiting hash");
`endif

endmodule
